### hw/rtl/mcep_pkg.sv
package mcep_pkg;

    localparam int SAMPLE_W    = 24;
    localparam int POS_W       = 18;
    localparam int FRAC_W      = 16;
    localparam int SPK_W       = 10;
    localparam int CFG_W       = 11;
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
    localparam int ROUND_SHIFT = 15;
    localparam int MIN_SPEAKERS = 2;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [POS_W-1:0]    t_pos;
    typedef logic [SPK_W-1:0]           t_spk;
    typedef logic [CFG_W-1:0]           t_cfg;
    typedef logic [GAIN_W-1:0]          t_gain;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    // Sine of a Q30 angle by a Taylor series up to the x^11 term, rounded to Q1.15.
    function automatic t_gain quarter_sine_q15(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        r;
        term = x;
        acc  = $signed(x);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd6;
        acc  = acc - $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd20;
        acc  = acc + $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd42;
        acc  = acc - $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd72;
        acc  = acc + $signed(term);
        term = ((((term * x) >> 30) * x) >> 30) / 64'd110;
        acc  = acc - $signed(term);
        if (acc < 0) begin
            acc = '0;
        end
        r = ($unsigned(acc) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return GAIN_W'(r);
    endfunction

endpackage

### hw/rtl/mcep_if.sv
interface mcep_in_if;
    logic               valid;
    logic               ready;
    mcep_pkg::t_sample  sample;
    mcep_pkg::t_pos     pan_position;

    modport source (output valid, output sample, output pan_position, input ready);
    modport sink (input valid, input sample, input pan_position, output ready);
endinterface

interface mcep_out_if;
    logic               valid;
    logic               ready;
    mcep_pkg::t_spk     first_speaker;
    mcep_pkg::t_sample  first_value;
    mcep_pkg::t_spk     second_speaker;
    mcep_pkg::t_sample  second_value;

    modport source (output valid, output first_speaker, output first_value,
                    output second_speaker, output second_value, input ready);
    modport sink (input valid, input first_speaker, input first_value,
                  input second_speaker, input second_value, output ready);
endinterface

interface mcep_cfg_if;
    logic               valid;
    logic               ready;
    mcep_pkg::t_cfg     speaker_count;

    modport source (output valid, output speaker_count, input ready);
    modport sink (input valid, input speaker_count, output ready);
endinterface

### hw/rtl/mcep_locate.sv
module mcep_locate #(
    parameter int  MAX_SPEAKERS     = 1024,
    parameter int  SINE_TABLE_DEPTH = 1024,
    localparam int CW               = $clog2(MAX_SPEAKERS + 1),
    localparam int IW               = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  mcep_pkg::t_stage_en i_en,
    input  mcep_pkg::t_sample   i_sample,
    input  mcep_pkg::t_pos      i_pan_position,
    input  logic [CW-1:0]       i_count,
    output mcep_pkg::t_sample   o_sample,
    output logic [CW-1:0]       o_first,
    output logic [CW-1:0]       o_second,
    output logic [IW-1:0]       o_idx_sin,
    output logic [IW-1:0]       o_idx_cos
);
    import mcep_pkg::*;

    localparam int SCALED_W = FRAC_W + CW;
    localparam int IDXP_W   = FRAC_W + IW;
    localparam int HALF     = 2 ** (FRAC_W - 1);

    logic [FRAC_W-1:0]   w_pos;
    logic [SCALED_W-1:0] w_scaled;
    logic [CW-1:0]       w_first;
    logic [CW-1:0]       w_next;
    logic [IDXP_W-1:0]   w_idx_prod;
    logic [IW-1:0]       w_idx;

    t_sample             r_sample1;
    logic [SCALED_W-1:0] r_scaled;
    logic [CW-1:0]       r_count1;

    t_sample             r_sample2;
    logic [CW-1:0]       r_first;
    logic [CW-1:0]       r_second;
    logic [IW-1:0]       r_idx_sin;
    logic [IW-1:0]       r_idx_cos;

    // Negative positions and positions at one or above collapse to zero.
    assign w_pos    = (i_pan_position[POS_W-1] || i_pan_position[FRAC_W]) ?
                      '0 : i_pan_position[FRAC_W-1:0];
    assign w_scaled = SCALED_W'(w_pos) * SCALED_W'(i_count);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_sample1 <= i_sample;
            r_scaled  <= w_scaled;
            r_count1  <= i_count;
        end
    end

    assign w_first    = r_scaled[SCALED_W-1:FRAC_W];
    assign w_next     = w_first + CW'(1);
    assign w_idx_prod = IDXP_W'(r_scaled[FRAC_W-1:0]) * IDXP_W'(SINE_TABLE_DEPTH)
                        + IDXP_W'(HALF);
    assign w_idx      = w_idx_prod[IDXP_W-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sample2 <= r_sample1;
            r_first   <= w_first;
            r_second  <= (w_next == r_count1) ? '0 : w_next;
            r_idx_sin <= w_idx;
            r_idx_cos <= IW'(SINE_TABLE_DEPTH) - w_idx;
        end
    end

    assign o_sample  = r_sample2;
    assign o_first   = r_first;
    assign o_second  = r_second;
    assign o_idx_sin = r_idx_sin;
    assign o_idx_cos = r_idx_cos;

endmodule

### hw/rtl/mcep_gain_rom.sv
module mcep_gain_rom #(
    parameter int  MAX_SPEAKERS     = 1024,
    parameter int  SINE_TABLE_DEPTH = 1024,
    localparam int CW               = $clog2(MAX_SPEAKERS + 1),
    localparam int IW               = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic                i_clk,
    input  mcep_pkg::t_stage_en i_en,
    input  mcep_pkg::t_sample   i_sample,
    input  logic [CW-1:0]       i_first,
    input  logic [CW-1:0]       i_second,
    input  logic [IW-1:0]       i_idx_sin,
    input  logic [IW-1:0]       i_idx_cos,
    output mcep_pkg::t_sample   o_sample,
    output logic [CW-1:0]       o_first,
    output logic [CW-1:0]       o_second,
    output mcep_pkg::t_gain     o_gain_sin,
    output mcep_pkg::t_gain     o_gain_cos
);
    import mcep_pkg::*;

    t_gain         w_rom [SINE_TABLE_DEPTH+1];

    t_sample       r_sample;
    logic [CW-1:0] r_first;
    logic [CW-1:0] r_second;
    t_gain         r_gain_sin;
    t_gain         r_gain_cos;

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] ANGLE = (64'(k) * PI_HALF_Q30 + 64'(SINE_TABLE_DEPTH / 2))
                                        / 64'(SINE_TABLE_DEPTH);
        assign w_rom[k] = quarter_sine_q15(ANGLE);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sample   <= i_sample;
            r_first    <= i_first;
            r_second   <= i_second;
            r_gain_sin <= w_rom[i_idx_sin];
            r_gain_cos <= w_rom[i_idx_cos];
        end
    end

    assign o_sample   = r_sample;
    assign o_first    = r_first;
    assign o_second   = r_second;
    assign o_gain_sin = r_gain_sin;
    assign o_gain_cos = r_gain_cos;

endmodule

### hw/rtl/mcep_scale.sv
module mcep_scale #(
    parameter int  MAX_SPEAKERS = 1024,
    localparam int CW           = $clog2(MAX_SPEAKERS + 1)
) (
    input  logic                i_clk,
    input  mcep_pkg::t_stage_en i_en,
    input  mcep_pkg::t_sample   i_sample,
    input  logic [CW-1:0]       i_first,
    input  logic [CW-1:0]       i_second,
    input  mcep_pkg::t_gain     i_gain_sin,
    input  mcep_pkg::t_gain     i_gain_cos,
    output mcep_pkg::t_spk      o_first_speaker,
    output mcep_pkg::t_sample   o_first_value,
    output mcep_pkg::t_spk      o_second_speaker,
    output mcep_pkg::t_sample   o_second_value
);
    import mcep_pkg::*;

    localparam int ROUND_HALF = 2 ** (ROUND_SHIFT - 1);

    logic signed [PROD_W-1:0] w_prod_cos;
    logic signed [PROD_W-1:0] w_prod_sin;
    logic signed [PROD_W-1:0] w_rnd_cos;
    logic signed [PROD_W-1:0] w_rnd_sin;

    logic signed [PROD_W-1:0] r_prod_cos;
    logic signed [PROD_W-1:0] r_prod_sin;
    logic [CW-1:0]            r_first4;
    logic [CW-1:0]            r_second4;

    t_spk                     r_first_speaker;
    t_sample                  r_first_value;
    t_spk                     r_second_speaker;
    t_sample                  r_second_value;

    assign w_prod_cos = i_sample * $signed({1'b0, i_gain_cos});
    assign w_prod_sin = i_sample * $signed({1'b0, i_gain_sin});

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_prod_cos <= w_prod_cos;
            r_prod_sin <= w_prod_sin;
            r_first4   <= i_first;
            r_second4  <= i_second;
        end
    end

    // Round half up, then drop the fraction bits of the gain.
    assign w_rnd_cos = r_prod_cos + PROD_W'(ROUND_HALF);
    assign w_rnd_sin = r_prod_sin + PROD_W'(ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_first_speaker  <= SPK_W'(r_first4);
            r_second_speaker <= SPK_W'(r_second4);
            r_first_value    <= w_rnd_cos[ROUND_SHIFT+SAMPLE_W-1:ROUND_SHIFT];
            r_second_value   <= w_rnd_sin[ROUND_SHIFT+SAMPLE_W-1:ROUND_SHIFT];
        end
    end

    assign o_first_speaker  = r_first_speaker;
    assign o_first_value    = r_first_value;
    assign o_second_speaker = r_second_speaker;
    assign o_second_value   = r_second_value;

endmodule

### hw/rtl/multichannel_equal_power_panner.sv
// Equal-power panner over a ring of speakers.
// The input channel carries one audio sample and its pan position per request. The
// output channel returns one request per input: the first speaker with the sample
// scaled by the cosine gain and the next speaker on the ring with the sine gain.
// The configuration channel writes the speaker count; it is always ready, and a
// value outside 2 to MAX_SPEAKERS is stored as MAX_SPEAKERS. Write it only while
// no request is in flight.
// Throughput is one request per clock cycle while the receiver accepts outputs. An
// accepted request passes through the register stages in order: position scaling,
// table index, quarter-sine table read, gain multiply, and rounding into the output
// register.
// Reset clears all stage valid bits and sets the speaker count to two; the gain
// table is constant and needs no fill.
// When the receiver stalls, the output request holds and upstream stages keep
// filling any empty slots; the input is refused only once every stage is full.
module multichannel_equal_power_panner #(
    parameter int MAX_SPEAKERS     = 1024,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcep_cfg_if.sink    i_cfg,
    mcep_in_if.sink     i_in,
    mcep_out_if.source  o_out
);
    import mcep_pkg::*;

    localparam int CW = $clog2(MAX_SPEAKERS + 1);
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [4:0]    r_valid;
    t_stage_en     w_en;

    t_sample       w_sample2;
    logic [CW-1:0] w_first2;
    logic [CW-1:0] w_second2;
    logic [IW-1:0] w_idx_sin;
    logic [IW-1:0] w_idx_cos;

    t_sample       w_sample3;
    logic [CW-1:0] w_first3;
    logic [CW-1:0] w_second3;
    t_gain         w_gain_sin;
    t_gain         w_gain_cos;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(MIN_SPEAKERS);
        end else if (i_cfg.valid) begin
            if (32'(i_cfg.speaker_count) < 32'(MIN_SPEAKERS) ||
                32'(i_cfg.speaker_count) > 32'(MAX_SPEAKERS)) begin
                r_count <= CW'(MAX_SPEAKERS);
            end else begin
                r_count <= CW'(i_cfg.speaker_count);
            end
        end
    end

    always_comb begin
        w_en.s5 = !r_valid[4] || o_out.ready;
        w_en.s4 = !r_valid[3] || w_en.s5;
        w_en.s3 = !r_valid[2] || w_en.s4;
        w_en.s2 = !r_valid[1] || w_en.s3;
        w_en.s1 = !r_valid[0] || w_en.s2;
    end

    assign i_in.ready  = w_en.s1;
    assign o_out.valid = r_valid[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en.s1) begin
                r_valid[0] <= i_in.valid;
            end
            if (w_en.s2) begin
                r_valid[1] <= r_valid[0];
            end
            if (w_en.s3) begin
                r_valid[2] <= r_valid[1];
            end
            if (w_en.s4) begin
                r_valid[3] <= r_valid[2];
            end
            if (w_en.s5) begin
                r_valid[4] <= r_valid[3];
            end
        end
    end

    mcep_locate #(
        .MAX_SPEAKERS     (MAX_SPEAKERS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_locate (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_sample       (i_in.sample),
        .i_pan_position (i_in.pan_position),
        .i_count        (r_count),
        .o_sample       (w_sample2),
        .o_first        (w_first2),
        .o_second       (w_second2),
        .o_idx_sin      (w_idx_sin),
        .o_idx_cos      (w_idx_cos)
    );

    mcep_gain_rom #(
        .MAX_SPEAKERS     (MAX_SPEAKERS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_gain_rom (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_sample   (w_sample2),
        .i_first    (w_first2),
        .i_second   (w_second2),
        .i_idx_sin  (w_idx_sin),
        .i_idx_cos  (w_idx_cos),
        .o_sample   (w_sample3),
        .o_first    (w_first3),
        .o_second   (w_second3),
        .o_gain_sin (w_gain_sin),
        .o_gain_cos (w_gain_cos)
    );

    mcep_scale #(
        .MAX_SPEAKERS (MAX_SPEAKERS)
    ) u_scale (
        .i_clk            (i_clk),
        .i_en             (w_en),
        .i_sample         (w_sample3),
        .i_first          (w_first3),
        .i_second         (w_second3),
        .i_gain_sin       (w_gain_sin),
        .i_gain_cos       (w_gain_cos),
        .o_first_speaker  (o_out.first_speaker),
        .o_first_value    (o_out.first_value),
        .o_second_speaker (o_out.second_speaker),
        .o_second_value   (o_out.second_value)
    );

    a_input_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_valid == '1)
    ) else $error("Input refused while a pipeline stage is empty.");

    a_accept_enters_pipeline: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_valid[0]
    ) else $error("Accepted request did not enter the first stage.");

    a_second_is_next_on_ring: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.second_speaker == '0 ||
                         o_out.second_speaker == SPK_W'(o_out.first_speaker + 1'b1))
    ) else $error("Second speaker is not the ring neighbor of the first.");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mcep_pkg::*;

    localparam int TABLE_DEPTH    = 1024;
    localparam int RING_MAX       = 1024;
    localparam int IDLE_PCT       = 28;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_AT_RESULT = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int BUSY_LO        = 900;
    localparam int BUSY_HI        = 1200;
    localparam int STALL_LIMIT    = 4000;

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_COUNT_WRITE,
        OP_WAIT_DRAIN
    } t_pan_op_kind;

    typedef struct {
        t_pan_op_kind kind;
        t_sample      sample;
        t_pos         pos;
        t_cfg         count;
    } t_pan_op;

    typedef struct packed {
        t_spk    first_spk;
        t_sample first_val;
        t_spk    second_spk;
        t_sample second_val;
    } t_pan_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mcep_cfg_if cfg_ch ();
    mcep_in_if  in_ch ();
    mcep_out_if out_ch ();

    multichannel_equal_power_panner #(
        .MAX_SPEAKERS     (RING_MAX),
        .SINE_TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [15:0]  sine_lut [0:TABLE_DEPTH];
    t_pan_op      pending_ops [$];
    t_pan_result  expected_pans [$];
    int unsigned  ring_size;
    int           error_count = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           settle_wait = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int           stall_cycles = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] sine_q15_entry(int unsigned k);
        longint unsigned angle;
        longint unsigned power;
        longint          acc;
        longint unsigned rounded;
        int              n;
        angle = (longint'(k) * PI_HALF_Q30 + TABLE_DEPTH / 2) / TABLE_DEPTH;
        power = angle;
        acc   = longint'(angle);
        for (n = 1; n <= 5; n++) begin
            power = (power * angle) >> 30;
            power = (power * angle) >> 30;
            power = power / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(power);
            end else begin
                acc = acc + longint'(power);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        rounded = (longint'(acc) + 16384) >> 15;
        if (rounded > 32768) begin
            rounded = 32768;
        end
        return rounded[15:0];
    endfunction

    function automatic t_sample apply_gain(t_sample smp, logic [15:0] gain);
        longint prod;
        prod = longint'(smp) * longint'({1'b0, gain});
        prod = (prod + 16384) >>> 15;
        return prod[SAMPLE_W-1:0];
    endfunction

    function automatic t_pan_result pan_sample(t_sample smp, t_pos position);
        logic [15:0] pos;
        logic [31:0] scaled;
        int unsigned spk_a;
        int unsigned spk_b;
        int unsigned lut_idx;
        t_pan_result res;
        if (position < 0 || position >= 65536) begin
            pos = '0;
        end else begin
            pos = position[15:0];
        end
        scaled = pos * ring_size;
        spk_a  = scaled[31:16];
        spk_b  = spk_a + 1;
        if (spk_b >= ring_size) begin
            spk_b = 0;
        end
        lut_idx = (int'(scaled[15:0]) * TABLE_DEPTH + 32768) >> 16;
        if (lut_idx > TABLE_DEPTH) begin
            lut_idx = TABLE_DEPTH;
        end
        res.first_spk  = spk_a[SPK_W-1:0];
        res.first_val  = apply_gain(smp, sine_lut[TABLE_DEPTH - lut_idx]);
        res.second_spk = spk_b[SPK_W-1:0];
        res.second_val = apply_gain(smp, sine_lut[lut_idx]);
        return res;
    endfunction

    function automatic int unsigned ring_size_from(t_cfg value);
        if (value < MIN_SPEAKERS || value > RING_MAX) begin
            return RING_MAX;
        end
        return value;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("tb_top: mismatch on %s at result %0d: got %0d, expected %0d",
                 field, results_seen, got, want);
        error_count++;
    endtask

    task automatic push_sample(t_sample smp, t_pos position);
        t_pan_op op;
        op.kind   = OP_SAMPLE;
        op.sample = smp;
        op.pos    = position;
        op.count  = '0;
        pending_ops.push_back(op);
    endtask

    task automatic push_count(t_cfg value);
        t_pan_op op;
        op.kind   = OP_COUNT_WRITE;
        op.sample = '0;
        op.pos    = '0;
        op.count  = value;
        pending_ops.push_back(op);
    endtask

    task automatic push_drain();
        t_pan_op op;
        op.kind   = OP_WAIT_DRAIN;
        op.sample = '0;
        op.pos    = '0;
        op.count  = '0;
        pending_ops.push_back(op);
    endtask

    task automatic push_random_samples(int n);
        t_sample smp;
        t_pos    position;
        int      pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                smp = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            end else begin
                smp = t_sample'($urandom());
            end
            pick = $urandom_range(9);
            if (pick < 7) begin
                position = t_pos'($urandom_range(65535));
            end else if (pick == 7) begin
                position = $urandom_range(1) ? t_pos'(65535 - $urandom_range(3))
                                             : t_pos'($urandom_range(3));
            end else begin
                position = t_pos'($urandom());
            end
            push_sample(smp, position);
        end
    endtask

    always @(posedge clk) begin : driver
        bit offer_in;
        bit offer_cfg;
        bit idle_ok;
        if (!rst_n) begin
            in_ch.valid  <= 1'b0;
            cfg_ch.valid <= 1'b0;
            ring_size    = 2;
            settle_wait  = 0;
        end else begin
            offer_in  = in_ch.valid;
            offer_cfg = cfg_ch.valid;
            idle_ok   = !(items_sent >= BUSY_LO && items_sent < BUSY_HI);
            if (in_ch.valid && in_ch.ready) begin
                expected_pans.push_back(pan_sample(in_ch.sample, in_ch.pan_position));
                items_sent++;
                offer_in = 1'b0;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                ring_size = ring_size_from(cfg_ch.speaker_count);
                offer_cfg = 1'b0;
            end
            if (!offer_in && !offer_cfg && pending_ops.size() > 0) begin
                case (pending_ops[0].kind)
                    OP_SAMPLE: begin
                        if (!(idle_ok && $urandom_range(99) < IDLE_PCT)) begin
                            in_ch.sample       <= pending_ops[0].sample;
                            in_ch.pan_position <= pending_ops[0].pos;
                            offer_in = 1'b1;
                            void'(pending_ops.pop_front());
                        end
                    end
                    default: begin
                        if (expected_pans.size() != 0) begin
                            settle_wait = 0;
                        end else if (settle_wait < SETTLE_CYCLES) begin
                            settle_wait++;
                        end else begin
                            settle_wait = 0;
                            if (pending_ops[0].kind == OP_COUNT_WRITE) begin
                                cfg_ch.speaker_count <= pending_ops[0].count;
                                offer_cfg = 1'b1;
                            end
                            void'(pending_ops.pop_front());
                        end
                    end
                endcase
            end
            in_ch.valid  <= offer_in;
            cfg_ch.valid <= offer_cfg;
        end
    end

    always @(posedge clk) begin : monitor
        t_pan_result got;
        t_pan_result want;
        bit          idle_ok;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.first_spk  = out_ch.first_speaker;
                got.first_val  = out_ch.first_value;
                got.second_spk = out_ch.second_speaker;
                got.second_val = out_ch.second_value;
                if (expected_pans.size() == 0) begin
                    $display("tb_top: result %0d arrived with no request pending", results_seen);
                    error_count++;
                end else begin
                    want = expected_pans.pop_front();
                    if (got.first_spk != want.first_spk) begin
                        report_mismatch("first_speaker", got.first_spk, want.first_spk);
                    end
                    if (got.first_val != want.first_val) begin
                        report_mismatch("first_value", got.first_val, want.first_val);
                    end
                    if (got.second_spk != want.second_spk) begin
                        report_mismatch("second_speaker", got.second_spk, want.second_spk);
                    end
                    if (got.second_val != want.second_val) begin
                        report_mismatch("second_value", got.second_val, want.second_val);
                    end
                end
                results_seen++;
            end
            idle_ok = !(results_seen >= BUSY_LO && results_seen < BUSY_HI);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen == HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_ok && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles == STALL_LIMIT) begin
                $display("tb_top: no progress for %0d cycles", STALL_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_cfg phase_counts [12];
        in_ch.valid          = 1'b0;
        in_ch.sample         = '0;
        in_ch.pan_position   = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.speaker_count = '0;
        out_ch.ready         = 1'b0;
        ring_size            = 2;

        for (int k = 0; k <= TABLE_DEPTH; k++) begin
            sine_lut[k] = sine_q15_entry(k);
        end

        // The speaker count is still at its reset value of two here.
        push_sample(24'sh7FFFFF, 18'sd0);
        push_sample(24'sh800000, 18'sd0);
        push_sample(24'sh7FFFFF, 18'sd65535);
        push_sample(24'sh800000, 18'sd65535);
        push_sample(24'sd0, 18'sd32768);
        push_sample(-24'sd1, 18'sd16384);
        push_sample(24'sd1, 18'sd49152);
        push_sample(24'sh800000, -18'sd1);
        push_sample(24'sh7FFFFF, -18'sd131072);
        push_sample(24'sh7FFFFF, 18'sd131071);
        push_sample(24'sh800000, 18'sd65536);
        push_sample(24'sd123456, 18'sd1);
        push_sample(-24'sd654321, 18'sd32767);
        push_sample(24'sh7FFFFF, 18'sd32768);
        push_sample(24'sh800000, 18'sd16384);
        push_sample(24'sh555555, 18'sd21845);
        push_sample(-24'sd5592406, 18'sd43690);
        push_sample(24'sh7FFFFF, 18'sd8192);
        push_sample(-24'sd2, 18'sd57344);
        push_sample(24'sd16384, 18'sd65534);

        phase_counts = '{11'd1024, 11'd0, 11'd2, 11'd1, 11'd1025, 11'd2047,
                         11'd3, 11'd5, 11'd8, 11'd1023, 11'd768, 11'd0};
        phase_counts[11] = $urandom_range(1) ? t_cfg'($urandom_range(2, 1024))
                                             : t_cfg'($urandom_range(2047));
        foreach (phase_counts[i]) begin
            push_count(phase_counts[i]);
            push_sample(24'sh7FFFFF, 18'sd65535);
            push_sample(24'sh800000, 18'sd0);
            push_sample(24'sh7FFFFF, 18'sd32768);
            push_random_samples(75);
            if (i % 3 == 1) begin
                push_drain();
            end
            push_random_samples(75);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_ch.valid || cfg_ch.valid
                || expected_pans.size() != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (error_count == 0 && expected_pans.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### multichannel_equal_power_panner.f
hw/rtl/mcep_pkg.sv
hw/rtl/mcep_if.sv
hw/rtl/mcep_locate.sv
hw/rtl/mcep_gain_rom.sv
hw/rtl/mcep_scale.sv
hw/rtl/multichannel_equal_power_panner.sv
verif/tb_top.sv
